### rtl/md5sh_pkg.sv
// Package for the MD5 stream hash block: constants, round tables, state enum.
// No dependencies.
package md5sh_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned RoundNum   = 64;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StFold,
    StPadFill,
    StOut
  } md5_state_e;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index used by round i
  function automatic logic [3:0] word_index(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

### rtl/md5sh_round.sv
// One MD5 step: mixing function, add chain and rotate for round i.
// Depends on md5sh_pkg.
module md5sh_round (
  input  logic [5:0]  rnd_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] w_i,
  output logic [31:0] b_next_o
);
  import md5sh_pkg::*;

  logic [31:0] f, t, r;
  logic [4:0]  s;

  always_comb begin
    case (rnd_i[5:4])
      2'd0: f = d_i ^ (b_i & (c_i ^ d_i));
      2'd1: f = c_i ^ (d_i & (b_i ^ c_i));
      2'd2: f = b_i ^ c_i ^ d_i;
      default: f = c_i ^ (b_i | ~d_i);
    endcase
    s = rot_amount(rnd_i);
    t = a_i + f + w_i + round_const(rnd_i);
    r = (t << s) | (t >> (6'd32 - {1'b0, s}));
    b_next_o = b_i + r;
  end
endmodule

### rtl/md5_stream_hash_top.sv
// MD5 stream hash top level: byte collection, word memory, round sequencer.
// Depends on md5sh_pkg and md5sh_round.
//
// Usage: one byte per input transfer (data_byte_i with has_data_i), and
// last_byte_i closes the message. The digest leaves on the output channel as
// one transfer (digest_low_o = bytes 0..7, digest_high_o = bytes 8..15).
// Bytes are packed into a 16 x 32-bit word memory with a registered read;
// bytes are collected in a holding register and each word is written once
// complete, so one byte is taken per cycle while stall_o is low.
// When the 64th byte of a block lands, the input stalls through the 64 rounds,
// each word read in the cycle ahead of its round, a spare cycle, then the fold.
// On a last transfer the block is padded in place (0x80, zeros, length), one
// word per cycle, taking one or two compressions, then the digest moves to the
// output register, which raises valid_o.
// The output register parts the two sides: a new message is taken while the
// digest waits under stall_i; stall_o stays high past the close only when a
// second digest is ready before the first is taken.
// Reset clears the chaining words, bit count, output valid and control
// state; the word memory is left as is.
module md5_stream_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_data_i,
  input  logic        last_byte_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] digest_low_o,
  output logic [63:0] digest_high_o
);
  import md5sh_pkg::*;

  md5_state_e  state_q, state_d;
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [63:0] cnt_q;
  logic [31:0] wbuf_q;        // word being collected
  logic [6:0]  rnd_q;         // round counter, 64 = spare cycle
  logic        final_q;       // compressing padded blocks
  logic        second_q;      // another pad block follows
  logic        pend_q;        // full block closed the message
  logic [3:0]  pidx_q;        // padding word index
  logic [63:0] plen_q;        // length latched for padding
  logic [5:0]  pfill_q;       // fill at close
  logic        outv_q;        // output register holds a digest
  logic [63:0] dlo_q, dhi_q;  // output register
  logic        load_out;

  logic [31:0] mem [16];
  logic [31:0] rd_q;
  logic [3:0]  raddr;
  logic        we;
  logic [3:0]  waddr;
  logic [31:0] wdata;

  logic        acc;
  logic [5:0]  fill;
  logic [31:0] wnew;
  logic [31:0] b_next;

  assign fill   = cnt_q[8:3];
  assign acc    = valid_i && !stall_o;
  assign stall_o = (state_q != StIdle);
  assign valid_o = outv_q;
  assign load_out = (state_q == StOut) && (!outv_q || !stall_i);

  always_comb begin
    wnew = wbuf_q;
    case (fill[1:0])
      2'd0: wnew = {24'd0, data_byte_i};
      2'd1: wnew[15:8]  = data_byte_i;
      2'd2: wnew[23:16] = data_byte_i;
      default: wnew[31:24] = data_byte_i;
    endcase
  end

  // pad word for index pidx_q of the current pad block
  logic [31:0] pword;
  always_comb begin
    logic [31:0] m;
    m = '0;
    pword = '0;
    if (second_q) begin
      pword = '0;
    end else begin
      // partial word of data is in wbuf_q
      if (pidx_q == pfill_q[5:2]) begin
        case (pfill_q[1:0])
          2'd0: m = {24'd0, PadByte};
          2'd1: m = {16'd0, PadByte, wbuf_q[7:0]};
          2'd2: m = {8'd0, PadByte, wbuf_q[15:0]};
          default: m = {PadByte, wbuf_q[23:0]};
        endcase
        pword = m;
      end else if (pidx_q > pfill_q[5:2]) begin
        pword = '0;
      end else begin
        pword = rd_q; // unused: earlier words kept
      end
    end
    if (pfill_q < 6'd56 || second_q) begin
      if (pidx_q == 4'd14) pword = plen_q[31:0];
      if (pidx_q == 4'd15) pword = plen_q[63:32];
    end
  end

  md5sh_round u_round (
    .rnd_i   (rnd_q[5:0]),
    .a_i     (a_q),
    .b_i     (b_q),
    .c_i     (c_q),
    .d_i     (d_q),
    .w_i     (rd_q),
    .b_next_o(b_next)
  );

  // memory address/write selection
  always_comb begin
    raddr = word_index(rnd_q[5:0] + 6'd1);
    if (state_q == StIdle || state_q == StPadFill) raddr = word_index(6'd0);
    we    = 1'b0;
    waddr = fill[5:2];
    wdata = wnew;
    if (state_q == StIdle && acc && has_data_i && fill[1:0] == 2'd3) begin
      we = 1'b1;
    end else if (state_q == StPadFill) begin
      // words below the fill word keep their data
      if (second_q || pidx_q >= pfill_q[5:2]) begin
        we = 1'b1;
      end
      waddr = pidx_q;
      wdata = pword;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic [5:0] fill_after;
  assign fill_after = has_data_i ? fill + 6'd1 : fill;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (acc && has_data_i && fill == 6'd63) state_d = StRound;
        else if (acc && last_byte_i) state_d = StPadFill;
      end
      StRound:   if (rnd_q == 7'd64) state_d = StFold;
      StFold: begin
        if (pend_q) state_d = StPadFill;
        else if (!final_q) state_d = StIdle;
        else if (!second_q && pfill_q >= 6'd56) state_d = StPadFill;
        else state_d = StOut;
      end
      StPadFill: if (pidx_q == 4'd15) state_d = StRound;
      StOut:     if (load_out) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      h_q[0]   <= InitA;
      h_q[1]   <= InitB;
      h_q[2]   <= InitC;
      h_q[3]   <= InitD;
      cnt_q    <= '0;
      rnd_q    <= '0;
      final_q  <= 1'b0;
      second_q <= 1'b0;
      pidx_q   <= '0;
      pfill_q  <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          rnd_q <= '0;
          if (acc && has_data_i) cnt_q <= cnt_q + 64'd8;
          if (acc && last_byte_i) begin
            pend_q  <= has_data_i && fill == 6'd63;
            pfill_q <= fill_after;
            second_q <= 1'b0;
            pidx_q  <= '0;
          end
          if (acc && last_byte_i && !(has_data_i && fill == 6'd63)) final_q <= 1'b1;
        end
        StRound: if (rnd_q != 7'd64) rnd_q <= rnd_q + 7'd1;
        StFold: begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
          rnd_q  <= '0;
          if (pend_q) begin
            // full block closed the message: pad block of its own
            pend_q  <= 1'b0;
            final_q <= 1'b1;
            pidx_q  <= '0;
          end else if (final_q && !second_q && pfill_q >= 6'd56) begin
            second_q <= 1'b1;
            pidx_q   <= '0;
          end
        end
        StPadFill: begin
          pidx_q <= pidx_q + 4'd1;
          rnd_q  <= '0;
        end
        StOut: begin
          if (load_out) begin
            h_q[0]   <= InitA;
            h_q[1]   <= InitB;
            h_q[2]   <= InitC;
            h_q[3]   <= InitD;
            cnt_q    <= '0;
            final_q  <= 1'b0;
            second_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register: takes the digest once the previous one is gone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
      dlo_q  <= '0;
      dhi_q  <= '0;
    end else if (load_out) begin
      outv_q <= 1'b1;
      dlo_q  <= {h_q[1], h_q[0]};
      dhi_q  <= {h_q[3], h_q[2]};
    end else if (!stall_i) begin
      outv_q <= 1'b0;
    end
  end

  // latched length, collection word and round working registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && acc && has_data_i) wbuf_q <= wnew;
    if (state_q == StIdle && acc && last_byte_i)
      plen_q <= has_data_i ? cnt_q + 64'd8 : cnt_q;
    if (state_q == StFold || state_q == StIdle || state_q == StPadFill) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
    end else if (state_q == StRound && rnd_q != 7'd64) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_next;
    end
  end

  assign digest_low_o  = dlo_q;
  assign digest_high_o = dhi_q;

`ifndef SYNTH
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(digest_low_o))
    else $error("digest changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> stall_o)
    else $error("input open while busy");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q <= 7'd64)
    else $error("round counter overflow");
`endif
endmodule
